### sv/srfp_pkg.sv
package srfp_pkg;

  localparam int SERVO_COUNT = 4;
  localparam int TABLE_SLOTS = 4;
  localparam int SEARCH_SLOTS = (SERVO_COUNT < TABLE_SLOTS) ? SERVO_COUNT : TABLE_SLOTS;
  localparam int SERVO_IDX_W = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_TX_DONE = 2'd1;
  localparam logic [1:0] OP_READ_REQ = 2'd2;

  localparam logic [1:0] RES_ACCEPTED = 2'd0;
  localparam logic [1:0] RES_ECHO = 2'd1;
  localparam logic [1:0] RES_CHECKSUM = 2'd2;
  localparam logic [1:0] RES_UNKNOWN_ID = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_SERVO_ID_TABLE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_ADDR = 8'd1;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] POSITION_ADDR_RESET = 8'd56;
  localparam logic [15:0] FAILURE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_result;
    logic [1:0]  servo_index;
    logic [7:0]  servo_status;
    logic [15:0] present_position;
    logic        position_updated;
    logic [15:0] checksum_failures;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

### sv/srfp_core.sv
module srfp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  srfp_pkg::cfg_write_t cfg_wr,
  input  srfp_pkg::in_item_t  item,
  input  logic                item_valid,
  input  logic                go,
  output logic                emit,
  output srfp_pkg::out_item_t result
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_STATUS = 3'd3;
  localparam logic [2:0] PH_PARAM  = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;

  logic [31:0] id_table_r;
  logic [7:0]  pos_addr_r;

  logic [2:0]  phase_r, phase_nxt;
  logic        prev_ff_r, prev_ff_nxt;
  logic [7:0]  frame_id_r, frame_id_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [15:0] cap_pos_r, cap_pos_nxt;
  logic        pos_seen_r, pos_seen_nxt;
  logic        echo_r, echo_nxt;
  logic [7:0]  read_addr_r, read_addr_nxt;
  logic [15:0] fail_cnt_r, fail_cnt_nxt;

  localparam int SERVO_IDX_W_L = srfp_pkg::SERVO_IDX_W;

  logic [7:0]  param_cnt;
  logic [8:0]  param_addr;
  logic [8:0]  target_lo;
  logic [8:0]  target_hi;
  logic [7:0]  offset_inc;
  logic        hit_found;
  logic [SERVO_IDX_W_L-1:0] hit_idx;

  assign param_cnt  = (frame_len_r >= 8'd2) ? (frame_len_r - 8'd2) : 8'd0;
  assign param_addr = {1'b0, read_addr_r} + {1'b0, offset_r};
  assign target_lo  = {1'b0, pos_addr_r};
  assign target_hi  = {1'b0, pos_addr_r} + 9'd1;
  assign offset_inc = offset_r + 8'd1;

  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = srfp_pkg::SEARCH_SLOTS - 1; i >= 0; i--) begin
      if (id_table_r[8*i +: 8] == frame_id_r) begin
        hit_found = 1'b1;
        hit_idx   = SERVO_IDX_W_L'(i);
      end
    end
  end

  assign emit = item_valid && (item.op == srfp_pkg::OP_RX_BYTE) && (phase_r == PH_CHECK);

  always_comb begin
    phase_nxt     = phase_r;
    prev_ff_nxt   = prev_ff_r;
    frame_id_nxt  = frame_id_r;
    frame_len_nxt = frame_len_r;
    offset_nxt    = offset_r;
    sum_nxt       = sum_r;
    status_nxt    = status_r;
    cap_pos_nxt   = cap_pos_r;
    pos_seen_nxt  = pos_seen_r;
    echo_nxt      = echo_r;
    read_addr_nxt = read_addr_r;
    fail_cnt_nxt  = fail_cnt_r;

    result.frame_result      = srfp_pkg::RES_ACCEPTED;
    result.servo_index       = '0;
    result.servo_status      = status_r;
    result.present_position  = '0;
    result.position_updated  = 1'b0;
    result.checksum_failures = fail_cnt_r;

    case (item.op)
      srfp_pkg::OP_TX_DONE: begin
        echo_nxt = 1'b1;
      end
      srfp_pkg::OP_READ_REQ: begin
        read_addr_nxt = item.read_address;
      end
      srfp_pkg::OP_RX_BYTE: begin
        case (phase_r)
          PH_HUNT: begin
            if (item.rx_byte == srfp_pkg::HEADER_BYTE && prev_ff_r) begin
              prev_ff_nxt = 1'b0;
              phase_nxt   = PH_ID;
            end else begin
              prev_ff_nxt = (item.rx_byte == srfp_pkg::HEADER_BYTE);
            end
          end
          PH_ID: begin
            frame_id_nxt = item.rx_byte;
            sum_nxt      = item.rx_byte;
            phase_nxt    = PH_LEN;
          end
          PH_LEN: begin
            frame_len_nxt = item.rx_byte;
            sum_nxt       = sum_r + item.rx_byte;
            phase_nxt     = PH_STATUS;
          end
          PH_STATUS: begin
            status_nxt   = item.rx_byte;
            sum_nxt      = sum_r + item.rx_byte;
            offset_nxt   = '0;
            cap_pos_nxt  = '0;
            pos_seen_nxt = 1'b0;
            phase_nxt    = (param_cnt != 8'd0) ? PH_PARAM : PH_CHECK;
          end
          PH_PARAM: begin
            sum_nxt = sum_r + item.rx_byte;
            if (param_addr == target_lo &&
                ({1'b0, offset_r} + 9'd2) <= {1'b0, param_cnt}) begin
              cap_pos_nxt = {cap_pos_r[15:8], item.rx_byte};
            end else if (offset_r != 8'd0 && param_addr == target_hi &&
                         ({1'b0, offset_r} + 9'd1) <= {1'b0, param_cnt}) begin
              cap_pos_nxt  = {item.rx_byte, cap_pos_r[7:0]};
              pos_seen_nxt = 1'b1;
            end
            offset_nxt = offset_inc;
            if (offset_inc >= param_cnt) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (~sum_r != item.rx_byte) begin
              result.frame_result = srfp_pkg::RES_CHECKSUM;
              if (fail_cnt_r != srfp_pkg::FAILURE_MAX) begin
                fail_cnt_nxt = fail_cnt_r + 16'd1;
              end
            end else if (echo_r) begin
              result.frame_result = srfp_pkg::RES_ECHO;
            end else if (!hit_found) begin
              result.frame_result = srfp_pkg::RES_UNKNOWN_ID;
            end else begin
              result.frame_result = srfp_pkg::RES_ACCEPTED;
              result.servo_index  = hit_idx;
              if (pos_seen_r) begin
                result.present_position = cap_pos_r;
                result.position_updated = 1'b1;
              end
            end
            result.checksum_failures = fail_cnt_nxt;
            echo_nxt  = 1'b0;
            phase_nxt = PH_HUNT;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_table_r  <= '0;
      pos_addr_r  <= srfp_pkg::POSITION_ADDR_RESET;
      phase_r     <= PH_HUNT;
      prev_ff_r   <= 1'b0;
      frame_id_r  <= '0;
      frame_len_r <= '0;
      offset_r    <= '0;
      sum_r       <= '0;
      status_r    <= '0;
      cap_pos_r   <= '0;
      pos_seen_r  <= 1'b0;
      echo_r      <= 1'b0;
      read_addr_r <= '0;
      fail_cnt_r  <= '0;
    end else begin
      if (cfg_wr.en) begin
        if (cfg_wr.index == srfp_pkg::REG_SERVO_ID_TABLE) begin
          id_table_r <= cfg_wr.data;
        end else if (cfg_wr.index == srfp_pkg::REG_POSITION_ADDR) begin
          pos_addr_r <= cfg_wr.data[7:0];
        end
      end
      if (go) begin
        phase_r     <= phase_nxt;
        prev_ff_r   <= prev_ff_nxt;
        frame_id_r  <= frame_id_nxt;
        frame_len_r <= frame_len_nxt;
        offset_r    <= offset_nxt;
        sum_r       <= sum_nxt;
        status_r    <= status_nxt;
        cap_pos_r   <= cap_pos_nxt;
        pos_seen_r  <= pos_seen_nxt;
        echo_r      <= echo_nxt;
        read_addr_r <= read_addr_nxt;
        fail_cnt_r  <= fail_cnt_nxt;
      end
    end
  end

endmodule

### sv/servo_reply_frame_parser_unit.sv
// Reply frame parser for half-duplex serial servos.
// in_item carries one event per transfer: a received bus byte, a transmit
// notice that arms echo suppression, or the start address of a read request.
// out_item carries one result per completed frame (checksum byte taken):
// the frame verdict, matched table index, status byte, position word when
// the reply covered it, and the saturating checksum failure count.
// cfg_* writes register 0 (four packed servo ids) or register 1 (address of
// the present-position low byte); cfg_ready is always high. Write only idle.
// An item taken waits in the single input register; the parser then consumes
// it and registers any frame result in the output register. Throughput: one
// item per cycle, unless a frame-completing item meets a held result.
// When the receiver stalls, the output register holds; an item that completes
// a frame then waits in the input register, and in_ready drops once that
// register is full. Items that give no result keep flowing past a held result.
// Synchronous reset clears the parser to header hunt, ids to zero, the
// position address to 56 and the failure count to zero; both channels empty.
module servo_reply_frame_parser_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srfp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srfp_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [srfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  srfp_pkg::in_item_t   s1_item_r;
  logic                 s1_valid_r, s1_valid_nxt;
  srfp_pkg::out_item_t  out_item_r;
  logic                 out_valid_r, out_valid_nxt;
  srfp_pkg::out_item_t  core_result;
  srfp_pkg::cfg_write_t cfg_wr;
  logic                 core_emit;
  logic                 out_free;
  logic                 s1_go;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!core_emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  srfp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .item       (s1_item_r),
    .item_valid (s1_valid_r),
    .go         (s1_go),
    .emit       (core_emit),
    .result     (core_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go && core_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (s1_go && core_emit) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost a stalled item");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && core_emit) |-> out_free)
    else $error("result overwrote an untaken result");

  a_pos_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.position_updated) |->
      (out_item_r.frame_result == srfp_pkg::RES_ACCEPTED))
    else $error("position reported for a rejected frame");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.frame_result != srfp_pkg::RES_ACCEPTED) |->
      (out_item_r.servo_index == '0 && out_item_r.present_position == '0))
    else $error("rejected frame carries index or position");

  a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.frame_result == srfp_pkg::RES_CHECKSUM) |->
      (out_item_r.checksum_failures != '0))
    else $error("checksum error without failure count");

endmodule
